// File: rtl/core/chebyshev_recurrence_eval_defines.svh
// ----------------------------------------------------------------------------
// Chebyshev evaluator assertion macros
// Shared property shorthands for the port checker; clock i_clk, reset i_rst_n.
// ----------------------------------------------------------------------------
`ifndef CHEBYSHEV_RECURRENCE_EVAL_DEFINES_SVH
`define CHEBYSHEV_RECURRENCE_EVAL_DEFINES_SVH

// cond at one edge implies expr at the next edge
`define CRE_ASSERT_NEXT(lbl, cond, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (expr)) \
        else $error("cre: next-cycle check failed");

// cond at one edge implies sig unchanged at the next edge
`define CRE_ASSERT_HOLD(lbl, cond, sig) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> $stable(sig)) \
        else $error("cre: hold check failed");

`endif

// File: rtl/core/cre_pkg.sv
// ----------------------------------------------------------------------------
// Chebyshev evaluator package
// Widths, register indexes, command struct and Q16.16 round/saturate helpers.
// ----------------------------------------------------------------------------
package cre_pkg;

    localparam int MAX_DEGREE = 64;
    localparam int STEP_W     = $clog2(MAX_DEGREE);
    localparam int Q_W        = 32;
    localparam int PROD_W     = 2 * Q_W;
    localparam int DEG_W      = 7;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_DEGREE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = CFG_IDX_W'(2);

    typedef logic signed [Q_W-1:0]    t_q;
    typedef logic signed [PROD_W-1:0] t_wide;

    localparam t_q Q_ONE     = 32'sd65536;
    localparam t_q Q_NEG_ONE = -32'sd65536;
    localparam t_wide Q_MAX_W = 64'sd2147483647;
    localparam t_wide Q_MIN_W = -64'sd2147483648;

    typedef struct packed {
        t_q   value;
        logic clip;
    } t_q_sat;

    typedef struct packed {
        logic load_x;     // capture input word
        logic mul_en;     // load product register
        logic mul_sel_x;  // product is scale * x, else y * d1
        logic init_y;     // form y, seed recurrence
        logic step;       // one recurrence step
        logic finish;     // form result into output register
    } t_dp_cmd;

    function automatic t_wide rnd_q(input t_wide v);
        t_wide t;
        t = v + 64'sd32768;
        return t >>> 16;
    endfunction

    function automatic t_q_sat sat_q(input t_wide v);
        t_q_sat r;
        if (v > Q_MAX_W) begin
            r.value = Q_MAX_W[Q_W-1:0];
            r.clip  = 1'b1;
        end else if (v < Q_MIN_W) begin
            r.value = Q_MIN_W[Q_W-1:0];
            r.clip  = 1'b1;
        end else begin
            r.value = v[Q_W-1:0];
            r.clip  = 1'b0;
        end
        return r;
    endfunction

endpackage

// File: rtl/core/cre_dp.sv
// ----------------------------------------------------------------------------
// Chebyshev evaluator datapath
// Shared 32x32 multiplier, round/saturate stage, recurrence and output regs.
// ----------------------------------------------------------------------------
module cre_dp (
    input  logic            i_clk,
    input  cre_pkg::t_dp_cmd i_cmd,
    input  cre_pkg::t_q     i_sample_x,
    input  cre_pkg::t_q     i_scale,
    input  cre_pkg::t_q     i_offset,
    output cre_pkg::t_q     o_poly_value,
    output logic            o_saturated
);
    import cre_pkg::*;

    t_q     r_x;
    t_q     r_y;
    t_q     r_d1;
    t_q     r_d2;
    t_wide  r_prod;
    logic   r_clip;
    t_q     r_poly;
    logic   r_sat;

    t_q     mul_a;
    t_q     mul_b;
    t_q_sat s_p;
    t_q_sat s_ysum;
    t_q_sat s_dbl;
    t_q_sat s_nd;
    t_q_sat s_res;

    always_comb begin
        mul_a  = i_cmd.mul_sel_x ? i_scale : r_y;
        mul_b  = i_cmd.mul_sel_x ? r_x : r_d1;
        s_p    = sat_q(rnd_q(r_prod));
        s_ysum = sat_q(PROD_W'(s_p.value) + PROD_W'(i_offset));
        s_dbl  = sat_q(PROD_W'(s_p.value) <<< 1);
        s_nd   = sat_q(PROD_W'(s_dbl.value) - PROD_W'(r_d2));
        s_res  = sat_q(PROD_W'(s_p.value) - PROD_W'(r_d2));
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_x) begin
            r_x <= i_sample_x;
        end
        if (i_cmd.mul_en) begin
            r_prod <= mul_a * mul_b;
        end
        if (i_cmd.init_y) begin
            r_y    <= s_ysum.value;
            r_clip <= s_p.clip | s_ysum.clip;
            r_d1   <= '0;
            r_d2   <= Q_NEG_ONE;
        end
        if (i_cmd.step) begin
            r_d1   <= s_nd.value;
            r_d2   <= r_d1;
            r_clip <= r_clip | s_p.clip | s_dbl.clip | s_nd.clip;
        end
        if (i_cmd.finish) begin
            r_poly <= s_res.value;
            r_sat  <= r_clip | s_p.clip | s_res.clip;
        end
    end

    assign o_poly_value = r_poly;
    assign o_saturated  = r_sat;

endmodule

// File: rtl/core/cre_ctrl.sv
// ----------------------------------------------------------------------------
// Chebyshev evaluator controller
// Sequences setup, recurrence steps and final step; owns handshake flags.
// ----------------------------------------------------------------------------
module cre_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    input  logic [cre_pkg::DEG_W-1:0]   i_degree,
    output cre_pkg::t_dp_cmd            o_cmd
);
    import cre_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_Y,
        ST_ADD_Y,
        ST_MUL,
        ST_ACC
    } t_state;

    t_state              r_state;
    logic [STEP_W-1:0]   r_steps;
    logic [STEP_W-1:0]   r_count;
    logic                r_out_valid;

    logic [STEP_W-1:0]   n_steps;
    logic [31:0]         deg_ext;
    logic [31:0]         deg_clamp;
    logic [31:0]         steps_ext;
    logic                accept;
    logic                more;
    logic                out_free;

    always_comb begin
        deg_ext   = 32'(i_degree);
        deg_clamp = (deg_ext > 32'(MAX_DEGREE)) ? 32'(MAX_DEGREE) : deg_ext;
        steps_ext = (deg_clamp >= 32'd2) ? deg_clamp - 32'd1 : 32'd0;
        n_steps   = STEP_W'(steps_ext);
    end

    assign accept   = i_in_valid && (r_state == ST_IDLE);
    assign more     = r_count < r_steps;
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_cmd           = '0;
        o_cmd.load_x    = accept;
        o_cmd.mul_en    = (r_state == ST_MUL_Y) || (r_state == ST_MUL);
        o_cmd.mul_sel_x = (r_state == ST_MUL_Y);
        o_cmd.init_y    = (r_state == ST_ADD_Y);
        o_cmd.step      = (r_state == ST_ACC) && more;
        o_cmd.finish    = (r_state == ST_ACC) && !more && out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_steps     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready && !o_cmd.finish) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_steps <= n_steps;
                        r_state <= ST_MUL_Y;
                    end
                end
                ST_MUL_Y: begin
                    r_state <= ST_ADD_Y;
                end
                ST_ADD_Y: begin
                    r_count <= '0;
                    r_state <= ST_MUL;
                end
                ST_MUL: begin
                    r_state <= ST_ACC;
                end
                ST_ACC: begin
                    if (more) begin
                        r_count <= r_count + 1'b1;
                        r_state <= ST_MUL;
                    end else if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// File: rtl/core/chebyshev_recurrence_eval.sv
// ----------------------------------------------------------------------------
// Chebyshev recurrence evaluator
// Evaluates T(steps), with steps as below, at y = scale*x + offset in saturating Q16.16.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid/o_in_ready) takes one word, sample_x. Output
// channel (o_out_valid/i_out_ready) returns poly_value and the saturated flag.
// Registers are written through i_cfg_we/i_cfg_index/i_cfg_data; the user
// must write them only while idle, which the block does not enforce. Index
// 0 degree, 1 scale_coef, 2 offset_coef; other indexes are ignored. With
// steps = min(degree, 64) - 1 (0 for degree below 2), a word passes ST_MUL_Y
// and ST_ADD_Y, then steps recurrence steps and a final step that writes the
// result. Each step is one pass through the single 32x32 multiplier (ST_MUL)
// and the round/saturate/subtract stage (ST_ACC).
// One word is in flight at a time; o_in_ready is high while idle, even when
// a finished result still sits in the output register. A stalled receiver
// holds the output register; the next result waits in its final step until
// the register frees. Reset (synchronous, active low) empties the pipeline,
// drops o_out_valid and sets degree 0, scale 1.0, offset 0.
// ----------------------------------------------------------------------------
module chebyshev_recurrence_eval (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [cre_pkg::Q_W-1:0] i_sample_x,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [cre_pkg::Q_W-1:0] o_poly_value,
    output logic                          o_saturated,
    input  logic                          i_cfg_we,
    input  logic [cre_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [cre_pkg::Q_W-1:0]       i_cfg_data
);
    import cre_pkg::*;

    logic [DEG_W-1:0] r_degree;
    t_q               r_scale;
    t_q               r_offset;
    t_dp_cmd          cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_degree <= '0;
            r_scale  <= Q_ONE;
            r_offset <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DEGREE: r_degree <= i_cfg_data[DEG_W-1:0];
                CFG_SCALE:  r_scale  <= i_cfg_data;
                CFG_OFFSET: r_offset <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    cre_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_degree    (r_degree),
        .o_cmd       (cmd)
    );

    cre_dp u_dp (
        .i_clk        (i_clk),
        .i_cmd        (cmd),
        .i_sample_x   (i_sample_x),
        .i_scale      (r_scale),
        .i_offset     (r_offset),
        .o_poly_value (o_poly_value),
        .o_saturated  (o_saturated)
    );

endmodule

// File: rtl/core/cre_checker.sv
// ----------------------------------------------------------------------------
// Chebyshev evaluator port checker
// Port-level checks on handshake and sequencing, bound to the top level.
// ----------------------------------------------------------------------------
`include "chebyshev_recurrence_eval_defines.svh"

module cre_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          o_in_ready,
    input  logic                          o_out_valid,
    input  logic                          i_out_ready,
    input  logic signed [cre_pkg::Q_W-1:0] o_poly_value
);
    logic in_acc;
    logic out_stall;

    assign in_acc    = i_in_valid && o_in_ready;
    assign out_stall = o_out_valid && !i_out_ready;

    `CRE_ASSERT_NEXT(a_out_valid_hold, out_stall, o_out_valid)
    `CRE_ASSERT_HOLD(a_out_word_hold, out_stall, o_poly_value)
    `CRE_ASSERT_NEXT(a_one_in_flight, in_acc, !o_in_ready)
    `CRE_ASSERT_NEXT(a_no_instant_result, in_acc, !$rose(o_out_valid))

endmodule

bind chebyshev_recurrence_eval cre_checker u_cre_checker (.*);
